@@ rtl/mr46_pkg.sv @@
package mr46_pkg;

  localparam int unsigned ADDR4_W  = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned HALF_W   = 64;
  localparam int unsigned TAIL_W   = ADDR4_W + PORT_W;
  localparam int unsigned CFG_DW   = 64;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned STAT_W   = 2;

  localparam logic [4:0] PSID_OFF_RST = 5'd6;

  typedef enum logic [CFG_AW-1:0] {
    REG_PREFIX_HIGH = 3'd0,
    REG_PREFIX_LEN  = 3'd1,
    REG_IPV4_LEN    = 3'd2,
    REG_EA_LEN      = 3'd3,
    REG_PSID_OFF    = 3'd4
  } cfg_idx_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_PORT = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  typedef struct packed {
    logic [HALF_W-1:0] prefix_high;
    logic [6:0]        prefix_len;
    logic [5:0]        ipv4_len;
    logic [5:0]        ea_len;
    logic [4:0]        psid_off;
  } cfg_t;

  // after field extraction
  typedef struct packed {
    status_t            status;
    logic [ADDR4_W-1:0] addr;
    logic [ADDR4_W-1:0] suffix;
    logic [PORT_W-1:0]  psid;
    logic [5:0]         p;
    logic [4:0]         q;
  } fld_t;

  // after packing the suffix and PSID
  typedef struct packed {
    status_t           status;
    logic [TAIL_W-1:0] tail;
    logic [6:0]        sh;
    logic [HALF_W-1:0] prefix_keep;
    logic [HALF_W-1:0] low;
  } pack_t;

  typedef struct packed {
    status_t           status;
    logic [HALF_W-1:0] high;
    logic [HALF_W-1:0] low;
  } res_t;

endpackage

@@ rtl/mr46_chan_if.sv @@
interface mr46_in_if;
  logic                           valid;
  logic                           ready;
  logic [mr46_pkg::ADDR4_W-1:0]   ipv4_addr;
  logic [mr46_pkg::PORT_W-1:0]    port_number;

  modport source (output valid, output ipv4_addr, output port_number, input ready);
  modport sink   (input valid, input ipv4_addr, input port_number, output ready);
endinterface

interface mr46_out_if;
  logic                           valid;
  logic                           ready;
  logic [mr46_pkg::HALF_W-1:0]    ipv6_high;
  logic [mr46_pkg::HALF_W-1:0]    ipv6_low;
  logic [mr46_pkg::STAT_W-1:0]    status;

  modport source (output valid, output ipv6_high, output ipv6_low, output status,
                  input ready);
  modport sink   (input valid, input ipv6_high, input ipv6_low, input status,
                  output ready);
endinterface

@@ rtl/mr46_cfg_regs.sv @@
module mr46_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [mr46_pkg::CFG_AW-1:0] cfg_index,
  input  logic [mr46_pkg::CFG_DW-1:0] cfg_data,
  output mr46_pkg::cfg_t              cfg
);

  mr46_pkg::cfg_t cfg_r;
  mr46_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (mr46_pkg::cfg_idx_t'(cfg_index))
        mr46_pkg::REG_PREFIX_HIGH: cfg_nxt.prefix_high = cfg_data;
        mr46_pkg::REG_PREFIX_LEN:  cfg_nxt.prefix_len  = cfg_data[6:0];
        mr46_pkg::REG_IPV4_LEN:    cfg_nxt.ipv4_len    = cfg_data[5:0];
        mr46_pkg::REG_EA_LEN:      cfg_nxt.ea_len      = cfg_data[5:0];
        mr46_pkg::REG_PSID_OFF:    cfg_nxt.psid_off    = cfg_data[4:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prefix_high <= '0;
      cfg_r.prefix_len  <= '0;
      cfg_r.ipv4_len    <= '0;
      cfg_r.ea_len      <= '0;
      cfg_r.psid_off    <= mr46_pkg::PSID_OFF_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/mr46_field_stage.sv @@
module mr46_field_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mr46_pkg::cfg_t               cfg,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic [mr46_pkg::ADDR4_W-1:0] ipv4_addr,
  input  logic [mr46_pkg::PORT_W-1:0]  port_number,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output mr46_pkg::fld_t               dn_data
);

  logic           vld_r;
  mr46_pkg::fld_t data_r;
  mr46_pkg::fld_t data_nxt;

  logic [5:0]  l4;
  logic [5:0]  p;
  logic [6:0]  l4_ea;
  logic [5:0]  q;
  logic [6:0]  a_q;
  logic [7:0]  len_sum;
  logic [6:0]  m_full;
  logic [3:0]  m;
  logic [15:0] port_win;
  logic        bad_port;
  logic        too_long;

  always_comb begin
    l4       = (cfg.ipv4_len > 6'd32) ? 6'd32 : cfg.ipv4_len;
    p        = 6'd32 - l4;
    l4_ea    = {1'b0, l4} + {1'b0, cfg.ea_len};
    q        = (l4_ea > 7'd32) ? 6'(l4_ea - 7'd32) : 6'd0;
    a_q      = {2'b00, cfg.psid_off} + {1'b0, q};
    bad_port = (q != 6'd0) && (a_q > 7'd16);
    len_sum  = {1'b0, cfg.prefix_len} + {2'b00, p} + {2'b00, q};
    too_long = len_sum > 8'd64;
    // right shift that brings the PSID down; only meaningful when a+q <= 16
    m_full   = 7'd16 - a_q;
    m        = m_full[3:0];
    port_win = port_number & (16'hFFFF >> cfg.psid_off);

    data_nxt.addr   = ipv4_addr;
    data_nxt.suffix = ipv4_addr & (32'hFFFF_FFFF >> l4);
    data_nxt.psid   = (q != 6'd0) ? (port_win >> m) : 16'h0000;
    data_nxt.p      = p;
    data_nxt.q      = q[4:0];
    if (bad_port) begin
      data_nxt.status = mr46_pkg::ST_BAD_PORT;
    end else if (too_long) begin
      data_nxt.status = mr46_pkg::ST_TOO_LONG;
    end else begin
      data_nxt.status = mr46_pkg::ST_OK;
    end
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

@@ rtl/mr46_pack_stage.sv @@
module mr46_pack_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  mr46_pkg::cfg_t  cfg,
  input  logic            up_valid,
  output logic            up_ready,
  input  mr46_pkg::fld_t  up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output mr46_pkg::pack_t dn_data
);

  logic            vld_r;
  mr46_pkg::pack_t data_r;
  mr46_pkg::pack_t data_nxt;
  logic [7:0]      sh_full;

  always_comb begin
    // suffix then PSID, right-aligned; placed under the prefix next stage
    data_nxt.tail = (mr46_pkg::TAIL_W'(up_data.suffix) << up_data.q)
                  | mr46_pkg::TAIL_W'(up_data.psid);
    sh_full = 8'd64 - {1'b0, cfg.prefix_len} - {2'b00, up_data.p}
            - {3'b000, up_data.q};
    data_nxt.sh          = sh_full[6:0];
    data_nxt.prefix_keep = cfg.prefix_high & ~({mr46_pkg::HALF_W{1'b1}} >> cfg.prefix_len);
    data_nxt.low         = {16'h0000, up_data.addr, up_data.psid};
    data_nxt.status      = up_data.status;
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

@@ rtl/mr46_merge_stage.sv @@
module mr46_merge_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  mr46_pkg::pack_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output mr46_pkg::res_t  dn_data
);

  logic           vld_r;
  mr46_pkg::res_t data_r;
  mr46_pkg::res_t data_nxt;
  logic           ok;

  always_comb begin
    ok              = (up_data.status == mr46_pkg::ST_OK);
    data_nxt.status = up_data.status;
    // a shift of 64 only occurs with an empty tail
    data_nxt.high   = ok ? (up_data.prefix_keep
                            | (mr46_pkg::HALF_W'(up_data.tail) << up_data.sh))
                         : '0;
    data_nxt.low    = ok ? up_data.low : '0;
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

@@ rtl/map_rule_ipv4_to_ipv6_address.sv @@
// MAP-T address builder: one IPv4 address and port beat in, one 128-bit IPv6
// address beat out, under a single mapping rule held in five config registers
// (prefix, prefix length, IPv4 prefix length, EA length, PSID offset). Three
// register stages (field extraction, suffix/PSID packing, final placement
// under the prefix), a new beat accepted every cycle while out_chan is not
// stalled. Each stage only holds while its successor is full and stalled, so
// a stall backs up cleanly.
// status reports a bad port field (q nonzero and a + q > 16) or a rule
// running past bit 64; in both cases the address halves come out as zero.
// Write config only while the pipe is empty.
module map_rule_ipv4_to_ipv6_address (
  input  logic                        clk,
  input  logic                        rst_n,
  mr46_in_if.sink                     in_chan,
  mr46_out_if.source                  out_chan,
  input  logic                        cfg_we,
  input  logic [mr46_pkg::CFG_AW-1:0] cfg_index,
  input  logic [mr46_pkg::CFG_DW-1:0] cfg_data
);

  mr46_pkg::cfg_t  cfg;

  // stage 1 -> 2
  logic            fld_valid;
  logic            fld_ready;
  mr46_pkg::fld_t  fld_data;

  // stage 2 -> 3
  logic            pack_valid;
  logic            pack_ready;
  mr46_pkg::pack_t pack_data;

  mr46_pkg::res_t  res_data;

  mr46_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // stage 1: lengths, fault checks, IPv4 suffix mask, PSID cut from the port
  mr46_field_stage u_field (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .up_valid    (in_chan.valid),
    .up_ready    (in_chan.ready),
    .ipv4_addr   (in_chan.ipv4_addr),
    .port_number (in_chan.port_number),
    .dn_valid    (fld_valid),
    .dn_ready    (fld_ready),
    .dn_data     (fld_data)
  );

  // stage 2: suffix and PSID joined, placement shift and prefix mask worked out
  mr46_pack_stage u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (fld_valid),
    .up_ready (fld_ready),
    .up_data  (fld_data),
    .dn_valid (pack_valid),
    .dn_ready (pack_ready),
    .dn_data  (pack_data)
  );

  // stage 3: tail shifted under the prefix; this register is the output beat
  mr46_merge_stage u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (pack_valid),
    .up_ready (pack_ready),
    .up_data  (pack_data),
    .dn_valid (out_chan.valid),
    .dn_ready (out_chan.ready),
    .dn_data  (res_data)
  );

  assign out_chan.ipv6_high = res_data.high;
  assign out_chan.ipv6_low  = res_data.low;
  assign out_chan.status    = res_data.status;

endmodule
